### src/ole_pkg.sv
`timescale 1ns / 1ps
package ole_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;

  typedef enum logic [2:0] {
    FN_INS_HEAD  = 3'd0,
    FN_INS_TAIL  = 3'd1,
    FN_INS_AFTER = 3'd2,
    FN_DELETE    = 3'd3,
    FN_SEARCH    = 3'd4,
    FN_UPDATE    = 3'd5
  } func_t;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_BUSY = 1'b1
  } state_t;

  // per-cycle control broadcast to every cell
  typedef struct packed {
    logic  apply;
    func_t op;
  } ctl_t;

endpackage

### src/ole_if.sv
`timescale 1ns / 1ps
interface ole_cmd_if;
  logic               valid;
  logic               ready;
  logic [2:0]         func;
  logic signed [31:0] key;
  logic signed [31:0] value;

  modport source (output valid, output func, output key, output value, input ready);
  modport sink   (input valid, input func, input key, input value, output ready);
endinterface

interface ole_res_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] data_out;

  modport source (output valid, output status, output data_out, input ready);
  modport sink   (input valid, input status, input data_out, output ready);
endinterface

### src/ole_cell.sv
`timescale 1ns / 1ps
module ole_cell
  import ole_pkg::*;
(
  input  logic              clk,
  input  ctl_t              ctl,
  input  logic [DATA_W-1:0] cmd_value,
  input  logic [DATA_W-1:0] key,
  input  logic              occ,        // entry holds a live value
  input  logic              tail,       // first free slot
  input  logic [DATA_W-1:0] left_val,
  input  logic [DATA_W-1:0] right_val,
  input  logic              hit_in,     // a match lies further up the chain
  input  logic              left_first, // neighbor above is the first match
  input  logic [DATA_W-1:0] sel_in,
  output logic [DATA_W-1:0] val,
  output logic              hit_out,
  output logic              first,
  output logic [DATA_W-1:0] sel_out
);

  logic [DATA_W-1:0] val_r;
  logic [DATA_W-1:0] val_nxt;
  logic              match;

  assign match   = occ && (val_r == key);
  assign first   = match && !hit_in;
  assign hit_out = hit_in || match;
  assign sel_out = sel_in | (first ? val_r : '0);
  assign val     = val_r;

  always_comb begin
    val_nxt = val_r;
    if (ctl.apply) begin
      case (ctl.op)
        FN_INS_HEAD: val_nxt = left_val;
        FN_INS_TAIL: begin
          if (tail) val_nxt = cmd_value;
        end
        FN_INS_AFTER: begin
          if (left_first) val_nxt = cmd_value;
          else if (hit_in) val_nxt = left_val;
        end
        FN_DELETE: begin
          if (hit_out) val_nxt = right_val;
        end
        FN_UPDATE: begin
          if (first) val_nxt = cmd_value;
        end
        default: val_nxt = val_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

### src/ordered_list_engine.sv
`timescale 1ns / 1ps
// ordered_list_engine: ordered list of up to CAPACITY signed 32-bit values.
// in_ch carries one command per beat (func, key, value); out_ch returns one
// beat per command (status, data_out). func: insert head, insert tail,
// insert after key, delete, search, update; status: done, miss, full.
// Storage is a row of cells, one entry each, head in cell 0. A command is
// latched when taken and applied in the busy state: every cell compares its
// entry with the key at once, a hit flag ripples down the row to mark the
// first match, and each cell loads its own, its neighbor's or the new value.
// A new command is not taken until the last one has been applied: the idle
// (accept) and busy (apply) states alternate, and the apply runs through the
// compare/ripple path of the cell row.
// The result sits in an output register; a new command is taken while it
// waits. If out_ch stalls with a result still held, the next command waits
// in the apply cycle and in_ch.ready stays low until the slot frees.
// Reset (rst_n low, synchronous) empties the list and drops any pending
// result; entry storage is not cleared, only the fill count.
// Unused func codes change nothing and return miss with zero data.
module ordered_list_engine
  import ole_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  ole_cmd_if.sink      in_ch,
  ole_res_if.source    out_ch
);

  state_t state_r, state_nxt;

  logic [2:0]        func_r;
  logic [DATA_W-1:0] key_r;
  logic [DATA_W-1:0] value_r;
  logic [CNT_W-1:0]  count_r, count_nxt;

  logic              out_valid_r, out_valid_nxt;
  status_t           status_r, status_nxt;
  logic [DATA_W-1:0] data_r, data_nxt;

  logic in_fire;
  logic apply;
  logic full;
  logic found;
  logic is_ins;
  func_t op;
  ctl_t  ctl;

  logic [DATA_W-1:0] vals      [CAPACITY];
  logic              firsts    [CAPACITY];
  logic              hit_chain [CAPACITY+1];
  logic [DATA_W-1:0] sel_chain [CAPACITY+1];

  assign op      = func_t'(func_r);
  assign full    = (count_r == CNT_W'(CAPACITY));
  assign in_fire = in_ch.valid && in_ch.ready;
  assign is_ins  = (op == FN_INS_HEAD) || (op == FN_INS_TAIL) || (op == FN_INS_AFTER);
  assign found   = hit_chain[CAPACITY];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_ch.valid) state_nxt = S_BUSY;
      S_BUSY: if (!out_valid_r || out_ch.ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    in_ch.ready = 1'b0;
    apply       = 1'b0;
    unique case (state_r)
      S_IDLE: in_ch.ready = 1'b1;
      S_BUSY: apply = !out_valid_r || out_ch.ready;
      default: ;
    endcase
  end

  // inserts into a full list leave the cells alone
  assign ctl.apply = apply && !(is_ins && full);
  assign ctl.op    = op;

  assign hit_chain[0] = 1'b0;
  assign sel_chain[0] = '0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_W-1:0] left_v;
    logic [DATA_W-1:0] right_v;
    logic              left_f;

    if (g == 0) begin : g_head
      assign left_v = value_r;
      assign left_f = 1'b0;
    end else begin : g_mid
      assign left_v = vals[g-1];
      assign left_f = firsts[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign right_v = vals[g];
    end else begin : g_inner
      assign right_v = vals[g+1];
    end

    ole_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .cmd_value  (value_r),
      .key        (key_r),
      .occ        (CNT_W'(g) < count_r),
      .tail       (CNT_W'(g) == count_r),
      .left_val   (left_v),
      .right_val  (right_v),
      .hit_in     (hit_chain[g]),
      .left_first (left_f),
      .sel_in     (sel_chain[g]),
      .val        (vals[g]),
      .hit_out    (hit_chain[g+1]),
      .first      (firsts[g]),
      .sel_out    (sel_chain[g+1])
    );
  end

  // result and fill count
  always_comb begin
    status_nxt    = ST_MISS;
    data_nxt      = '0;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (apply) begin
      out_valid_nxt = 1'b1;
      case (op) inside
        FN_INS_HEAD, FN_INS_TAIL: begin
          if (full) status_nxt = ST_FULL;
          else begin
            status_nxt = ST_DONE;
            count_nxt  = count_r + CNT_W'(1);
          end
        end
        FN_INS_AFTER: begin
          if (full) status_nxt = ST_FULL;
          else if (found) begin
            status_nxt = ST_DONE;
            count_nxt  = count_r + CNT_W'(1);
          end
        end
        FN_DELETE: begin
          if (found) begin
            status_nxt = ST_DONE;
            data_nxt   = sel_chain[CAPACITY];
            count_nxt  = count_r - CNT_W'(1);
          end
        end
        FN_SEARCH: begin
          if (found) begin
            status_nxt = ST_DONE;
            data_nxt   = sel_chain[CAPACITY];
          end
        end
        FN_UPDATE: begin
          if (found) begin
            status_nxt = ST_DONE;
            data_nxt   = value_r;
          end
        end
        default: status_nxt = ST_MISS;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      func_r  <= in_ch.func;
      key_r   <= in_ch.key;
      value_r <= in_ch.value;
    end
    if (apply) begin
      status_r <= status_nxt;
      data_r   <= data_nxt;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.status   = status_r;
  assign out_ch.data_out = data_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("fill count above capacity");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == S_BUSY)
    else $error("accepted command not taken up");

  a_apply_result: assert property (@(posedge clk) disable iff (!rst_n)
    apply |=> out_valid_r)
    else $error("applied command gave no result");

  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !apply |=> $stable(count_r))
    else $error("fill count moved without a command");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (apply && status_nxt == ST_FULL) |-> full && !ctl.apply)
    else $error("full status with room left or cells changed");

endmodule

### test/ordered_list_engine_tb.sv
`timescale 1ns / 1ps
module ordered_list_engine_tb;
  import ole_pkg::*;

  // Spare command codes: the block must treat them as a miss with no change.
  localparam logic [2:0]  FN_SPARE_6 = 3'd6;
  localparam logic [2:0]  FN_SPARE_7 = 3'd7;

  localparam logic [31:0] MIN_VAL = 32'h8000_0000;
  localparam logic [31:0] MAX_VAL = 32'h7FFF_FFFF;
  localparam logic [31:0] NEG_ONE = 32'hFFFF_FFFF;

  localparam int RAND_PER_PHASE = 630;
  localparam int EPISODE_LEN    = 40;   // beats between changes of insert bias
  localparam int HOLD_CYCLES    = 150;  // long receiver stall
  localparam int TAIL_CYCLES    = 8;    // settle time after the last result
  localparam int CYCLE_LIMIT    = 400_000;
  localparam int MAX_PRINTS     = 40;

  typedef struct {
    status_t     status;
    logic [31:0] data;
  } list_result_t;

  // ---------------------------------------------------------------------------
  // List tracker: keeps its own copy of the list, computes the status and data
  // word of each accepted command, and matches returned beats in order.
  // ---------------------------------------------------------------------------
  class list_scoreboard;
    logic [31:0]  entries [CAPACITY];
    int unsigned  fill;
    list_result_t expected_q [$];
    int           errors;
    int           checked;
    int           n_done;
    int           n_miss;
    int           n_full;
    int unsigned  peak_fill;

    function new();
      fill      = 0;
      errors    = 0;
      checked   = 0;
      n_done    = 0;
      n_miss    = 0;
      n_full    = 0;
      peak_fill = 0;
    endfunction

    // index of the first entry equal to key, or fill if there is none
    function int unsigned find_first(logic [31:0] key);
      for (int unsigned i = 0; i < fill; i++)
        if (entries[i] == key) return i;
      return fill;
    endfunction

    function void insert_at(int unsigned pos, logic [31:0] val);
      for (int unsigned i = fill; i > pos; i--)
        entries[i] = entries[i - 1];
      entries[pos] = val;
      fill++;
    endfunction

    function void remove_at(int unsigned pos);
      for (int unsigned i = pos; i + 1 < fill; i++)
        entries[i] = entries[i + 1];
      fill--;
    endfunction

    function logic [31:0] entry_at(int unsigned idx);
      return entries[idx];
    endfunction

    function int outstanding();
      return expected_q.size();
    endfunction

    function void note_command(logic [2:0] fn, logic [31:0] key, logic [31:0] val);
      list_result_t res;
      int unsigned  pos;
      logic         full;
      res.status = ST_MISS;
      res.data   = '0;
      full       = (fill >= CAPACITY);
      pos        = find_first(key);
      case (fn) inside
        FN_INS_HEAD, FN_INS_TAIL: begin
          if (full) begin
            res.status = ST_FULL;
          end else begin
            insert_at((fn == FN_INS_HEAD) ? 0 : fill, val);
            res.status = ST_DONE;
          end
        end
        FN_INS_AFTER: begin
          // fullness wins over a missing key
          if (full) begin
            res.status = ST_FULL;
          end else if (pos < fill) begin
            insert_at(pos + 1, val);
            res.status = ST_DONE;
          end
        end
        FN_DELETE: begin
          if (pos < fill) begin
            res.data = entries[pos];
            remove_at(pos);
            res.status = ST_DONE;
          end
        end
        FN_SEARCH: begin
          if (pos < fill) begin
            res.data   = entries[pos];
            res.status = ST_DONE;
          end
        end
        FN_UPDATE: begin
          if (pos < fill) begin
            entries[pos] = val;
            res.data     = val;
            res.status   = ST_DONE;
          end
        end
        default: ;
      endcase
      if (fill > peak_fill) peak_fill = fill;
      expected_q.push_back(res);
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      if (errors < MAX_PRINTS)
        $display("[%0t] mismatch at result %0d: %s got 0x%08h expected 0x%08h",
                 $time, checked, what, got, want);
      errors++;
    endtask

    task check_result(logic [1:0] st, logic [31:0] d);
      list_result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected beat, status/data", {30'd0, st}, d);
        return;
      end
      want = expected_q.pop_front();
      if (st !== want.status)
        report_mismatch("status", {30'd0, st}, {30'd0, want.status});
      if (d !== want.data)
        report_mismatch("data_out", d, want.data);
      case (want.status)
        ST_DONE: n_done++;
        ST_FULL: n_full++;
        default: n_miss++;
      endcase
      checked++;
    endtask
  endclass

  // ---------------------------------------------------------------------------
  // Clock, reset, channels, DUT
  // ---------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  ole_cmd_if cmd_ch ();
  ole_res_if res_ch ();

  ordered_list_engine DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (cmd_ch),
    .out_ch (res_ch)
  );

  list_scoreboard board;

  int   send_idle_pct;   // chance per beat that the sender inserts a gap
  int   recv_idle_pct;   // chance per cycle that the receiver drops ready
  logic rx_hold;         // long receiver stall in progress
  int   beats_sent;
  int   cycle_count;
  event rx_hold_kick;

  initial begin
    board         = new();
    rst_n         = 1'b0;
    cmd_ch.valid  = 1'b0;
    cmd_ch.func   = '0;
    cmd_ch.key    = '0;
    cmd_ch.value  = '0;
    res_ch.ready  = 1'b0;
    rx_hold       = 1'b0;
    send_idle_pct = 30;
    recv_idle_pct = 46;
    beats_sent    = 0;
    cycle_count   = 0;
  end

  // Watchdog: generous bound on total run time.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, board.outstanding());
      $display("ordered_list_engine test failed");
      $finish;
    end
  end

  // Receiver: checks each result beat and throttles ready.
  always @(posedge clk) begin
    if (rst_n && res_ch.valid && res_ch.ready)
      board.check_result(res_ch.status, res_ch.data_out);
    if (rx_hold)
      res_ch.ready <= 1'b0;
    else
      res_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Long receiver stall, timed here so the sender keeps pushing meanwhile;
  // the block fills its output slot and must back-pressure in_ch.
  initial begin
    forever begin
      @(rx_hold_kick);
      rx_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      rx_hold <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender tasks
  // ---------------------------------------------------------------------------

  // Offer one command and wait for its beat. valid is only dropped when a gap
  // is taken, so back-to-back beats never lower and raise it in one step.
  task automatic drive_cmd(input logic [2:0] fn, input logic [31:0] k,
                           input logic [31:0] v);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < send_idle_pct) @(posedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.func  <= fn;
    cmd_ch.key   <= k;
    cmd_ch.value <= v;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    board.note_command(fn, k, v);
    beats_sent++;
  endtask

  // Stop offering and wait until every result has come back.
  // Sampled on the falling edge so the receiver's pop has settled.
  task automatic drain();
    cmd_ch.valid <= 1'b0;
    @(negedge clk);
    while (board.outstanding() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    int unsigned r;
    logic [31:0] v;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      v = $urandom_range(0, 8) - 32'd4;      // small pool -> duplicate entries
    end else if (r < 50) begin
      case ($urandom_range(0, 3))
        0:       v = MIN_VAL;
        1:       v = MAX_VAL;
        2:       v = NEG_ONE;
        default: v = '0;
      endcase
    end else begin
      v = $urandom;
    end
    return v;
  endfunction

  // Random command; ins_bias is the percent of inserts, so some episodes
  // push the list to full and others drain it back to empty.
  task automatic send_random_cmd(input int ins_bias);
    int unsigned r;
    logic [2:0]  fn;
    logic [31:0] k;
    r = $urandom_range(0, 99);
    if (r < 2) begin
      fn = $urandom_range(0, 1) ? FN_SPARE_7 : FN_SPARE_6;
    end else if (r < ins_bias) begin
      case ($urandom_range(0, 2))
        0:       fn = FN_INS_HEAD;
        1:       fn = FN_INS_TAIL;
        default: fn = FN_INS_AFTER;
      endcase
    end else begin
      case ($urandom_range(0, 2))
        0:       fn = FN_DELETE;
        1:       fn = FN_SEARCH;
        default: fn = FN_UPDATE;
      endcase
    end
    // keys mostly hit a live entry so delete/update/insert-after do real work
    r = $urandom_range(0, 99);
    if (board.fill != 0 && r < 60)
      k = board.entry_at($urandom_range(0, board.fill - 1));
    else if (r < 80)
      k = $urandom_range(0, 8) - 32'd4;
    else
      k = $urandom;
    drive_cmd(fn, k, pick_value());
  endtask

  task automatic run_random(input int count, input int hold_at);
    int bias;
    bias = 50;
    for (int n = 0; n < count; n++) begin
      if (n % EPISODE_LEN == 0) begin
        case ($urandom_range(0, 2))
          0:       bias = 15;
          1:       bias = 50;
          default: bias = 85;
        endcase
      end
      if (n == hold_at) -> rx_hold_kick;
      send_random_cmd(bias);
    end
  endtask

  // Directed opening: empty-list misses, spare codes, extreme values,
  // minus one as data, key-not-found, fill to capacity and full refusals.
  task automatic run_directed();
    drive_cmd(FN_DELETE,    '0,      '0);
    drive_cmd(FN_SEARCH,    '0,      '0);
    drive_cmd(FN_UPDATE,    '0,      MAX_VAL);
    drive_cmd(FN_INS_AFTER, '0,      32'd1);
    drive_cmd(FN_SPARE_6,   NEG_ONE, NEG_ONE);
    drive_cmd(FN_SPARE_7,   MIN_VAL, MAX_VAL);
    drive_cmd(FN_INS_HEAD,  '0,      MIN_VAL);
    drive_cmd(FN_INS_TAIL,  '0,      MAX_VAL);
    drive_cmd(FN_INS_AFTER, MIN_VAL, NEG_ONE);   // list: MIN, -1, MAX
    drive_cmd(FN_SEARCH,    NEG_ONE, '0);
    drive_cmd(FN_UPDATE,    MAX_VAL, '0);        // list: MIN, -1, 0
    drive_cmd(FN_DELETE,    NEG_ONE, '0);        // deleted data is all ones
    drive_cmd(FN_INS_AFTER, 32'd77,  32'd5);     // key absent
    for (int i = 0; i < CAPACITY - 2; i++)
      drive_cmd(FN_INS_TAIL, '0, 32'h5A5A_0000 + i);
    drive_cmd(FN_INS_HEAD,  '0,      32'd9);     // full
    drive_cmd(FN_INS_TAIL,  '0,      32'd9);     // full
    drive_cmd(FN_INS_AFTER, 32'd77,  32'd9);     // full beats missing key
    drive_cmd(FN_DELETE,    MIN_VAL, '0);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // phase A: sender idles 30%, receiver 46%; includes the long stall
    run_directed();
    run_random(RAND_PER_PHASE, 200);
    drain();

    // phase B: roles swapped
    send_idle_pct = 46;
    recv_idle_pct <= 30;
    run_random(RAND_PER_PHASE, -1);
    drain();

    // phase C: full rate on both sides
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    run_random(RAND_PER_PHASE, -1);
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d commands sent, %0d results checked in %0d cycles",
             beats_sent, board.checked, cycle_count);
    $display("outcomes: %0d done, %0d miss, %0d full; list grew to %0d of %0d entries",
             board.n_done, board.n_miss, board.n_full, board.peak_fill, CAPACITY);
    if (board.errors == 0 && board.outstanding() == 0) begin
      $display("ordered_list_engine test passed");
    end else begin
      $display("%0d mismatches", board.errors);
      $display("ordered_list_engine test failed");
    end
    $finish;
  end

endmodule
